### sv/slum_pkg.sv
// Package for the sorted list union merge block.
// Holds the command codes, the merge state type and the fixed field widths.
// Has no dependencies; every other file of the block imports it.
package slum_pkg;

    // Fixed widths of the request and result fields.
    localparam int VALUE_W   = 32;
    localparam int COMMAND_W = 2;
    localparam int UCOUNT_W  = 7;

    // Command codes carried by an input request.
    typedef enum logic [COMMAND_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MERGE  = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    // Merge sequencer states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } state_t;

endpackage

### sv/sorted_list_union_merge.sv
// Top level of the sorted list union merge block: two list memories and the merge sequencer.
// Depends on slum_pkg for command codes, the state type and field widths.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid, in_stall | command, value
//   output  | out_valid, out_stall | element, last, empty_res, union_count, overflow
//
// A load request (append to list A or B) is taken while idle, one per cycle.
// A merge request starts the sequencer, then one result per cycle follows, read through
// the single read port of each list memory; an empty merge gives one empty result.
// Input is stalled for the whole merge run; output stalls only pause the sequencer.
// Reset clears the list counts, the overflow flag and the sequencer; the list
// memories are not cleared and need no clearing pass.
module sorted_list_union_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [slum_pkg::COMMAND_W-1:0]       command,
    input  logic signed [slum_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [slum_pkg::VALUE_W-1:0]  element,
    output logic                                 last,
    output logic                                 empty_res,
    output logic [slum_pkg::UCOUNT_W-1:0]        union_count,
    output logic                                 overflow
);
    import slum_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int KW = $clog2(2 * LIST_DEPTH + 1);

    // List memories with one write port and one registered read port each.
    logic signed [VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic signed [VALUE_W-1:0] mem_b [LIST_DEPTH];
    logic signed [VALUE_W-1:0] rd_a_reg;
    logic signed [VALUE_W-1:0] rd_b_reg;
    logic                      we_a;
    logic                      we_b;

    // Control state.
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_a_reg, cnt_a_next;
    logic [CW-1:0]   cnt_b_reg, cnt_b_next;
    logic [CW-1:0]   idx_a_reg, idx_a_next;
    logic [CW-1:0]   idx_b_reg, idx_b_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            ovf_reg, ovf_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] element_reg, element_next;
    logic                      last_reg, last_next;
    logic                      empty_reg, empty_next;
    logic [UCOUNT_W-1:0]       ucount_reg, ucount_next;
    logic                      ovf_out_reg, ovf_out_next;

    // Merge step signals.
    logic                      in_accept;
    logic                      out_free;
    logic                      has_a;
    logic                      has_b;
    logic                      take_a;
    logic                      take_b;
    logic                      done;
    logic                      none_left;
    logic [KW-1:0]             k_plus;
    logic signed [VALUE_W-1:0] pick;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // The list memories: writes come from loads, reads follow the next head index.
    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[cnt_a_reg[AW-1:0]] <= value;
        end
        if (we_b)
        begin
            mem_b[cnt_b_reg[AW-1:0]] <= value;
        end
        rd_a_reg <= mem_a[idx_a_next[AW-1:0]];
        rd_b_reg <= mem_b[idx_b_next[AW-1:0]];
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            idx_a_reg     <= idx_a_next;
            idx_b_reg     <= idx_b_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        element_reg <= element_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
        ucount_reg  <= ucount_next;
        ovf_out_reg <= ovf_out_next;
    end

    // Head selection: equal heads give one copy and advance both lists.
    always_comb
    begin
        has_a  = (idx_a_reg < cnt_a_reg);
        has_b  = (idx_b_reg < cnt_b_reg);
        take_a = 1'b0;
        take_b = 1'b0;
        if (has_a && has_b)
        begin
            if (rd_a_reg == rd_b_reg)
            begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
            else if (rd_a_reg < rd_b_reg)
            begin
                take_a = 1'b1;
            end
            else
            begin
                take_b = 1'b1;
            end
        end
        else if (has_a)
        begin
            take_a = 1'b1;
        end
        else if (has_b)
        begin
            take_b = 1'b1;
        end
        none_left = !has_a && !has_b;
        pick      = take_a ? rd_a_reg : rd_b_reg;
        k_plus    = k_reg + KW'(1);
    end

    // Next state, loads and merge steps.
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        we_a           = 1'b0;
        we_b           = 1'b0;
        done           = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        element_next   = element_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ucount_next    = ucount_reg;
        ovf_out_next   = ovf_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (command)
                        CMD_LOAD_A:
                        begin
                            if (cnt_a_reg < CW'(LIST_DEPTH))
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (cnt_b_reg < CW'(LIST_DEPTH))
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_MERGE:
                        begin
                            state_next = ST_MERGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                // One union element per cycle while the output register can take it.
                if (out_free)
                begin
                    if (take_a)
                    begin
                        idx_a_next = idx_a_reg + CW'(1);
                    end
                    if (take_b)
                    begin
                        idx_b_next = idx_b_reg + CW'(1);
                    end
                    done = (idx_a_next >= cnt_a_reg) && (idx_b_next >= cnt_b_reg);
                    k_next         = k_plus;
                    out_valid_next = 1'b1;
                    element_next   = none_left ? '0 : pick;
                    last_next      = done;
                    empty_next     = none_left;
                    ucount_next    = (done && !none_left) ? UCOUNT_W'(k_plus) : '0;
                    ovf_out_next   = ovf_reg;
                    if (done)
                    begin
                        state_next = ST_IDLE;
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        idx_a_next = '0;
                        idx_b_next = '0;
                        k_next     = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign element     = element_reg;
    assign last        = last_reg;
    assign empty_res   = empty_reg;
    assign union_count = ucount_reg;
    assign overflow    = ovf_out_reg;

endmodule

### sv/slum_checker.sv
// Port-level checker for the sorted list union merge block, with its bind statement.
// Depends on slum_pkg for the command codes and field widths.
module slum_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [slum_pkg::COMMAND_W-1:0]       command,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [slum_pkg::VALUE_W-1:0]  element,
    input logic                                 last,
    input logic                                 empty_res,
    input logic [slum_pkg::UCOUNT_W-1:0]        union_count
);
    import slum_pkg::*;

    // A stalled result holds its element.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(element))
        else $error("stalled result changed");

    // An empty result is the final one and counts nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && (union_count == '0) && (element == '0))
        else $error("empty result malformed");

    // Only the final result carries a count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (union_count == '0) && !empty_res)
        else $error("count on a non-final result");

    // A non-empty run ends with a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !empty_res |-> (union_count != '0))
        else $error("final result without count");

    // A merge request blocks further requests in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_MERGE) |=> in_stall)
        else $error("request taken during merge");

endmodule

bind sorted_list_union_merge slum_checker u_slum_checker (.*);

### sim/sorted_list_union_merge_tb.sv
// Self-checking testbench for sorted_list_union_merge: random list loads and merges.
// Predicts each merge run from its own copy of both lists and checks every result.
// Depends on slum_pkg and the sorted_list_union_merge top level.
`timescale 1ns / 1ps

module sorted_list_union_merge_tb;

    import slum_pkg::*;

    localparam int LIST_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // One input request as queued for the driver.
    typedef struct {
        command_t                   cmd;
        logic signed [VALUE_W-1:0]  val;
    } list_req_t;

    // One predicted union element with its flags.
    typedef struct {
        logic signed [VALUE_W-1:0]  element;
        logic                       last;
        logic                       empty_res;
        logic [UCOUNT_W-1:0]        union_count;
        logic                       overflow;
    } union_res_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic [COMMAND_W-1:0]          command     = CMD_NONE;
    logic signed [VALUE_W-1:0]     value       = '0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic signed [VALUE_W-1:0]     element;
    logic                          last;
    logic                          empty_res;
    logic [UCOUNT_W-1:0]           union_count;
    logic                          overflow;

    // Requests waiting to be driven and union elements waiting to arrive.
    list_req_t                     pending_reqs[$];
    union_res_t                    union_expected[$];

    // Predicted contents of both lists and the dropped-load flag.
    logic signed [VALUE_W-1:0]     list_a_vals[$];
    logic signed [VALUE_W-1:0]     list_b_vals[$];
    logic                          ovf_pending = 1'b0;

    int                            planned_items   = 0;
    int                            accepted_count  = 0;
    int                            merges_seen     = 0;
    int                            empty_merges    = 0;
    int                            overflow_merges = 0;
    int                            results_checked = 0;
    int                            mismatch_count  = 0;
    int                            cycle_count     = 0;

    int                            gap_left   = 0;
    int                            stall_left = 0;
    int                            hold_left  = 0;
    bit                            in_burst   = 1'b0;
    bit                            out_burst  = 1'b0;
    logic                          hold_active = 1'b0;
    list_req_t                     next_req;

    sorted_list_union_merge #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .last        (last),
        .empty_res   (empty_res),
        .union_count (union_count),
        .overflow    (overflow)
    );

    // Free-running clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // List element: narrow span for many ties, full range, or the edges.
    function automatic logic signed [VALUE_W-1:0] draw_value(input int span);
        if (span == 0)
            return $signed($urandom_range(0, 12)) - 32'sd6;
        if (span == 1)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh8000_0001;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4:       return 32'sd1;
            5:       return 32'sh7FFF_FFFE;
            6:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Update the predicted lists for one accepted request; a merge queues its union.
    task automatic predict_union(input command_t cmd, input logic signed [VALUE_W-1:0] val);
        union_res_t                res;
        int                        ia;
        int                        ib;
        int                        n;
        logic signed [VALUE_W-1:0] pick;
        begin
            case (cmd)
                CMD_LOAD_A:
                begin
                    if (list_a_vals.size() < LIST_DEPTH)
                        list_a_vals.push_back(val);
                    else
                        ovf_pending = 1'b1;
                end
                CMD_LOAD_B:
                begin
                    if (list_b_vals.size() < LIST_DEPTH)
                        list_b_vals.push_back(val);
                    else
                        ovf_pending = 1'b1;
                end
                CMD_MERGE:
                begin
                    merges_seen++;
                    if (ovf_pending)
                        overflow_merges++;
                    if (list_a_vals.size() == 0 && list_b_vals.size() == 0)
                    begin
                        // Both lists empty: a single marker result.
                        res.element     = '0;
                        res.last        = 1'b1;
                        res.empty_res   = 1'b1;
                        res.union_count = '0;
                        res.overflow    = ovf_pending;
                        union_expected.push_back(res);
                        empty_merges++;
                    end
                    else
                    begin
                        // Walk both heads; a tie emits one copy and advances both.
                        ia = 0;
                        ib = 0;
                        n  = 0;
                        while (ia < list_a_vals.size() || ib < list_b_vals.size())
                        begin
                            if (ia < list_a_vals.size() && ib < list_b_vals.size())
                            begin
                                if (list_a_vals[ia] == list_b_vals[ib])
                                begin
                                    pick = list_a_vals[ia];
                                    ia++;
                                    ib++;
                                end
                                else if (list_a_vals[ia] < list_b_vals[ib])
                                begin
                                    pick = list_a_vals[ia];
                                    ia++;
                                end
                                else
                                begin
                                    pick = list_b_vals[ib];
                                    ib++;
                                end
                            end
                            else if (ia < list_a_vals.size())
                            begin
                                pick = list_a_vals[ia];
                                ia++;
                            end
                            else
                            begin
                                pick = list_b_vals[ib];
                                ib++;
                            end
                            n++;
                            res.element     = pick;
                            res.last        = (ia >= list_a_vals.size()
                                               && ib >= list_b_vals.size());
                            res.empty_res   = 1'b0;
                            res.union_count = res.last ? UCOUNT_W'(n) : '0;
                            res.overflow    = ovf_pending;
                            union_expected.push_back(res);
                        end
                    end
                    list_a_vals.delete();
                    list_b_vals.delete();
                    ovf_pending = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Queue one request for the driver; ignored commands are not counted.
    task automatic push_req(input command_t cmd, input logic signed [VALUE_W-1:0] val);
        list_req_t r;
        begin
            r.cmd = cmd;
            r.val = val;
            pending_reqs.push_back(r);
            if (cmd != CMD_NONE)
                planned_items++;
        end
    endtask

    // Build two lists, load them interleaved with some noise, then merge.
    task automatic add_merge_run(input int na, input int nb, input int span, input bit in_order);
        logic signed [VALUE_W-1:0] va[$];
        logic signed [VALUE_W-1:0] vb[$];
        logic signed [VALUE_W-1:0] v;
        int                        k;
        int                        m;
        int                        ia;
        int                        ib;
        begin
            // Insert in place so the lists come out ascending when asked.
            for (k = 0; k < na + nb; k++)
            begin
                v = draw_value(span);
                m = 0;
                if (k < na)
                begin
                    while (in_order && m < va.size() && va[m] <= v)
                        m++;
                    if (in_order)
                        va.insert(m, v);
                    else
                        va.push_back(v);
                end
                else
                begin
                    while (in_order && m < vb.size() && vb[m] <= v)
                        m++;
                    if (in_order)
                        vb.insert(m, v);
                    else
                        vb.push_back(v);
                end
            end
            ia = 0;
            ib = 0;
            while (ia < na || ib < nb)
            begin
                if ($urandom_range(0, 11) == 0)
                    push_req(CMD_NONE, $urandom);
                if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1))
                begin
                    push_req(CMD_LOAD_A, va[ia]);
                    ia++;
                end
                else
                begin
                    push_req(CMD_LOAD_B, vb[ib]);
                    ib++;
                end
            end
            push_req(CMD_MERGE, $urandom);
        end
    endtask

    // Driver: offers queued requests with random gaps; holds the payload while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_union(command_t'(command), value);
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    command  <= next_req.cmd;
                    value    <= next_req.val;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        in_burst = !in_burst;
                    gap_left = in_burst ? 0 : idle_span();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and draws random output stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (union_expected.size() == 0)
                begin
                    $display({"%0t: unexpected result element=%0d last=%0b empty=%0b",
                              " count=%0d ovf=%0b"},
                             $time, element, last, empty_res, union_count, overflow);
                    mismatch_count++;
                end
                else
                begin
                    if (element !== union_expected[0].element
                        || last !== union_expected[0].last
                        || empty_res !== union_expected[0].empty_res
                        || union_count !== union_expected[0].union_count
                        || overflow !== union_expected[0].overflow)
                    begin
                        $display({"%0t: expected element=%0d last=%0b empty=%0b",
                                  " count=%0d ovf=%0b, got element=%0d last=%0b",
                                  " empty=%0b count=%0d ovf=%0b"},
                                 $time, union_expected[0].element, union_expected[0].last,
                                 union_expected[0].empty_res, union_expected[0].union_count,
                                 union_expected[0].overflow, element, last, empty_res,
                                 union_count, overflow);
                        mismatch_count++;
                    end
                    void'(union_expected.pop_front());
                    results_checked++;
                end
            end
            if (hold_active)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    out_burst = !out_burst;
                if (!out_burst && $urandom_range(0, 3) == 0)
                    stall_left = idle_span();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Long receiver hold-off now and then, so the merge backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_active <= 1'b0;
        end
        else if (cycle_count % 1500 == 700)
        begin
            hold_left = 150;
            hold_active <= 1'b1;
        end
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int r;
        int na;
        int nb;

        // Directed: empty merge, ignored command, extremes with a tie, one-sided lists,
        // duplicates in one list, unsorted input and a single shared value.
        push_req(CMD_MERGE, 32'sh7FFF_FFFF);
        push_req(CMD_NONE, -32'sd1);
        push_req(CMD_LOAD_A, 32'sh8000_0000);
        push_req(CMD_LOAD_B, -32'sd1);
        push_req(CMD_LOAD_A, -32'sd1);
        push_req(CMD_LOAD_B, 32'sd5);
        push_req(CMD_LOAD_A, 32'sd0);
        push_req(CMD_LOAD_B, 32'sh7FFF_FFFF);
        push_req(CMD_MERGE, 32'sh8000_0000);
        push_req(CMD_LOAD_A, 32'sd7);
        push_req(CMD_MERGE, $urandom);
        push_req(CMD_LOAD_B, 32'sd1);
        push_req(CMD_LOAD_B, 32'sd1);
        push_req(CMD_MERGE, $urandom);
        push_req(CMD_LOAD_A, 32'sd3);
        push_req(CMD_LOAD_A, 32'sd1);
        push_req(CMD_LOAD_B, 32'sd2);
        push_req(CMD_MERGE, $urandom);
        push_req(CMD_LOAD_A, 32'sd4);
        push_req(CMD_LOAD_B, 32'sd4);
        push_req(CMD_MERGE, $urandom);

        // Both lists full with full-range values, then list A overrun.
        add_merge_run(LIST_DEPTH, LIST_DEPTH, 1, 1'b1);
        add_merge_run(LIST_DEPTH + 2, $urandom_range(0, 3), 0, 1'b1);

        // Random runs: mostly short sorted lists, a few near the depth or unsorted.
        while (planned_items < 255)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                na = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 2);
                nb = (r < 4) ? $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 2)
                             : $urandom_range(0, 6);
            end
            else
            begin
                na = $urandom_range(0, 8);
                nb = $urandom_range(0, 8);
            end
            add_merge_run(na, nb, $urandom_range(0, 2), $urandom_range(0, 9) != 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (union_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display({"Run covered %0d accepted requests and %0d merges",
                  " (%0d on empty lists, %0d after dropped loads)."},
                 accepted_count, merges_seen, empty_merges, overflow_merges);
        $display({"Checked %0d union elements in %0d cycles",
                  " with random gaps and long output hold-offs."},
                 results_checked, cycle_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
